@@ rtl/lamport_mutex_node_macros.svh @@
// Assertion macros used by the checker file of the mutual exclusion node.
`ifndef LAMPORT_MUTEX_NODE_MACROS_SVH
`define LAMPORT_MUTEX_NODE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lmx_pkg.sv @@
// Shared codes, field widths and types of the mutual exclusion node.
`timescale 1ns / 1ps
package lmx_pkg;

  localparam int PID_W      = 4;
  localparam int MODE_W     = 3;
  localparam int KIND_W     = 2;
  localparam int FAULT_W    = 2;
  localparam int NODES_W    = 5;
  localparam int RCNT_W     = 5;
  localparam int OUT_CLK_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LREQ = 3'd0,
    MODE_LREL = 3'd1,
    MODE_REQ  = 3'd2,
    MODE_REP  = 3'd3,
    MODE_REL  = 3'd4
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_REQ  = 2'd1,
    KIND_REP  = 2'd2,
    KIND_REL  = 2'd3
  } kind_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK    = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_t;

endpackage

@@ rtl/lmx_clk_unit.sv @@
// Saturating Lamport clock update: optional merge with a message clock, then one tick.
`timescale 1ns / 1ps
module lmx_clk_unit #(
  parameter int CLOCK_BITS = 32
) (
  input  logic [CLOCK_BITS-1:0]        cur_i,
  input  logic [lmx_pkg::OUT_CLK_W-1:0] msg_i,
  input  logic                         merge_i,
  output logic [CLOCK_BITS-1:0]        msg_sat_o,
  output logic [CLOCK_BITS-1:0]        next_o
);
  import lmx_pkg::*;

  localparam int WW = (CLOCK_BITS > OUT_CLK_W) ? CLOCK_BITS : OUT_CLK_W;
  localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

  logic [WW-1:0]         msg_w;
  logic [CLOCK_BITS-1:0] base;

  assign msg_w     = WW'(msg_i);
  assign msg_sat_o = (msg_w > WW'(CLK_MAX)) ? CLK_MAX : CLOCK_BITS'(msg_w);
  assign base      = (merge_i && (msg_sat_o > cur_i)) ? msg_sat_o : cur_i;
  assign next_o    = (base == CLK_MAX) ? base : base + CLOCK_BITS'(1);

endmodule

@@ rtl/lamport_mutex_node.sv @@
// Top level: one node of Lamport distributed mutual exclusion with a sorted request queue.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//   in      | in        | in_valid, in_stall | in_mode, in_msg_clock, in_msg_pid
//   out     | out       | out_valid,out_stall| out_send_kind .. out_fault
//
// An item without queue work goes from idle straight to the emit state; an insert
// or pop walks the queue memory one entry per cycle.
// One item is in flight at a time; in_stall is high while it is worked on.
// A finished result waits in the output register while out_stall is high.
// rst_n is synchronous; queue memory contents are left as they are.
`timescale 1ns / 1ps
module lamport_mutex_node #(
  parameter int MAX_NODES  = 16,
  parameter int CLOCK_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lmx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lmx_pkg::MODE_W-1:0]      in_mode,
  input  logic [lmx_pkg::OUT_CLK_W-1:0]   in_msg_clock,
  input  logic [lmx_pkg::PID_W-1:0]       in_msg_pid,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmx_pkg::KIND_W-1:0]      out_send_kind,
  output logic [lmx_pkg::OUT_CLK_W-1:0]   out_send_clock,
  output logic [lmx_pkg::PID_W-1:0]       out_send_dest,
  output logic                            out_granted,
  output logic [lmx_pkg::PID_W-1:0]       out_head_node,
  output logic                            out_queue_empty,
  output logic [lmx_pkg::FAULT_W-1:0]     out_fault
);
  import lmx_pkg::*;

  localparam int QAW = $clog2(MAX_NODES);
  localparam int QCW = $clog2(MAX_NODES + 1);
  localparam int NCW = (QCW > NODES_W) ? QCW : NODES_W;
  localparam int EW  = CLOCK_BITS + PID_W;
  localparam int WW  = (CLOCK_BITS > OUT_CLK_W) ? CLOCK_BITS : OUT_CLK_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK2,
    S_INS_START,
    S_INS_SCAN,
    S_POP_START,
    S_POP_SCAN,
    S_EMIT
  } state_t;

  state_t                 state_r;
  logic [CLOCK_BITS-1:0]  clk_r;
  logic [QCW-1:0]         qcnt_r;
  logic [QCW-1:0]         idx_r;
  logic [RCNT_W-1:0]      rcnt_r;
  logic                   pend_r;
  logic [PID_W-1:0]       head_r;
  logic [NODES_W-1:0]     num_nodes_r;
  logic [PID_W-1:0]       own_id_r;
  logic [CLOCK_BITS-1:0]  key_clk_r;
  logic [PID_W-1:0]       key_pid_r;
  kind_t                  kind_r;
  logic [OUT_CLK_W-1:0]   sclk_r;
  logic [PID_W-1:0]       dest_r;
  fault_t                 fault_r;

  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [OUT_CLK_W-1:0]   out_sclk_r;
  logic [PID_W-1:0]       out_dest_r;
  logic                   out_grant_r;
  logic [PID_W-1:0]       out_head_r;
  logic                   out_empty_r;
  fault_t                 out_fault_r;

  // queue memory: entry = {clock, node id}, sorted from address 0
  logic [EW-1:0]          qmem [MAX_NODES];
  logic [EW-1:0]          rd_data_r;
  logic                   mem_we;
  logic [QAW-1:0]         mem_waddr;
  logic [EW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [QAW-1:0]         mem_raddr;

  logic                   merge_sel;
  logic [CLOCK_BITS-1:0]  clk_next;
  logic [CLOCK_BITS-1:0]  msg_sat;
  logic [OUT_CLK_W-1:0]   clk_next_out;
  logic [CLOCK_BITS-1:0]  rd_clk;
  logic [PID_W-1:0]       rd_pid;
  logic                   key_before;
  logic                   ins_place;
  logic                   pop_last;
  logic                   q_full;
  logic                   q_empty;
  logic [NCW-1:0]         nodes_raw;
  logic [NCW-1:0]         nodes_eff;
  logic                   grant;

  assign merge_sel = (state_r == S_IDLE) &&
                     ((in_mode == MODE_REQ) || (in_mode == MODE_REP) || (in_mode == MODE_REL));

  lmx_clk_unit #(
    .CLOCK_BITS (CLOCK_BITS)
  ) u_clk_unit (
    .cur_i     (clk_r),
    .msg_i     (in_msg_clock),
    .merge_i   (merge_sel),
    .msg_sat_o (msg_sat),
    .next_o    (clk_next)
  );

  assign clk_next_out = OUT_CLK_W'(WW'(clk_next));

  assign rd_clk     = rd_data_r[EW-1:PID_W];
  assign rd_pid     = rd_data_r[PID_W-1:0];
  // new key goes ahead of an equal entry
  assign key_before = (key_clk_r < rd_clk) || ((key_clk_r == rd_clk) && (key_pid_r <= rd_pid));
  assign ins_place  = (idx_r == '0) || !key_before;
  assign pop_last   = (QCW'(idx_r + QCW'(1)) == qcnt_r);
  assign q_full     = (qcnt_r == QCW'(MAX_NODES));
  assign q_empty    = (qcnt_r == '0);

  assign nodes_raw = NCW'(num_nodes_r);
  assign nodes_eff = (nodes_raw < NCW'(2)) ? NCW'(2) :
                     (nodes_raw > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : nodes_raw;
  assign grant     = pend_r && (NCW'(rcnt_r) >= (nodes_eff - NCW'(1))) &&
                     !q_empty && (head_r == own_id_r);

  // Insert shifts from the tail down, pop from the head up; the read always
  // runs ahead of the write, so the two never hit the same entry.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_data_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      S_INS_START: begin
        mem_re    = 1'b1;
        mem_raddr = QAW'(qcnt_r - QCW'(1));
      end
      S_INS_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[QAW-1:0];
        mem_wdata = ins_place ? {key_clk_r, key_pid_r} : rd_data_r;
        mem_re    = !ins_place && (idx_r >= QCW'(2));
        mem_raddr = QAW'(idx_r - QCW'(2));
      end
      S_POP_START: begin
        mem_re    = 1'b1;
        mem_raddr = QAW'(1);
      end
      S_POP_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = QAW'(idx_r - QCW'(1));
        mem_re    = !pop_last;
        mem_raddr = QAW'(idx_r + QCW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= qmem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clk_r       <= '0;
      qcnt_r      <= '0;
      rcnt_r      <= '0;
      pend_r      <= 1'b0;
      head_r      <= '0;
      num_nodes_r <= NODES_W'(2);
      own_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_NODES: num_nodes_r <= cfg_wdata;
          CFG_OWN_ID:    own_id_r    <= cfg_wdata[PID_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // slot 0 mirrors into head_r so the result never waits on a memory read
      if (mem_we && (mem_waddr == '0)) begin
        head_r <= mem_wdata[PID_W-1:0];
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= KIND_NONE;
            sclk_r  <= '0;
            dest_r  <= '0;
            fault_r <= FAULT_OK;
            state_r <= S_EMIT;
            case (in_mode)
              MODE_LREQ: begin
                if (!pend_r) begin
                  clk_r     <= clk_next;
                  kind_r    <= KIND_REQ;
                  sclk_r    <= clk_next_out;
                  pend_r    <= 1'b1;
                  rcnt_r    <= '0;
                  key_clk_r <= clk_next;
                  key_pid_r <= own_id_r;
                  if (q_full) begin
                    fault_r <= FAULT_FULL;
                  end else begin
                    state_r <= S_INS_START;
                  end
                end
              end
              MODE_LREL: begin
                clk_r  <= clk_next;
                kind_r <= KIND_REL;
                sclk_r <= clk_next_out;
                pend_r <= 1'b0;
                rcnt_r <= '0;
                if (q_empty) begin
                  fault_r <= FAULT_EMPTY;
                end else begin
                  state_r <= S_POP_START;
                end
              end
              MODE_REQ: begin
                clk_r     <= clk_next;
                kind_r    <= KIND_REP;
                dest_r    <= in_msg_pid;
                key_clk_r <= msg_sat;
                key_pid_r <= in_msg_pid;
                state_r   <= S_TICK2;
              end
              MODE_REP: begin
                clk_r <= clk_next;
                if (rcnt_r != RCNT_MAX) begin
                  rcnt_r <= rcnt_r + RCNT_W'(1);
                end
              end
              MODE_REL: begin
                clk_r <= clk_next;
                if (q_empty) begin
                  fault_r <= FAULT_EMPTY;
                end else begin
                  state_r <= S_POP_START;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // REP goes out one tick after the merge
        S_TICK2: begin
          clk_r  <= clk_next;
          sclk_r <= clk_next_out;
          if (q_full) begin
            fault_r <= FAULT_FULL;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_INS_START;
          end
        end

        S_INS_START: begin
          idx_r   <= qcnt_r;
          state_r <= S_INS_SCAN;
        end

        S_INS_SCAN: begin
          if (ins_place) begin
            qcnt_r  <= qcnt_r + QCW'(1);
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r - QCW'(1);
          end
        end

        S_POP_START: begin
          idx_r <= QCW'(1);
          if (qcnt_r == QCW'(1)) begin
            qcnt_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_POP_SCAN;
          end
        end

        S_POP_SCAN: begin
          if (pop_last) begin
            qcnt_r  <= qcnt_r - QCW'(1);
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + QCW'(1);
          end
        end

        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_sclk_r  <= sclk_r;
            out_dest_r  <= dest_r;
            out_grant_r <= grant;
            out_head_r  <= q_empty ? '0 : head_r;
            out_empty_r <= q_empty;
            out_fault_r <= fault_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_send_kind   = out_kind_r;
  assign out_send_clock  = out_sclk_r;
  assign out_send_dest   = out_dest_r;
  assign out_granted     = out_grant_r;
  assign out_head_node   = out_head_r;
  assign out_queue_empty = out_empty_r;
  assign out_fault       = out_fault_r;

endmodule

@@ rtl/lmx_checker.sv @@
// Port-level checks of the mutual exclusion node, bound to the top level.
`timescale 1ns / 1ps
`include "lamport_mutex_node_macros.svh"
module lmx_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lmx_pkg::KIND_W-1:0]    out_send_kind,
  input logic [lmx_pkg::OUT_CLK_W-1:0] out_send_clock,
  input logic [lmx_pkg::PID_W-1:0]     out_send_dest,
  input logic                          out_granted,
  input logic [lmx_pkg::PID_W-1:0]     out_head_node,
  input logic                          out_queue_empty
);
  import lmx_pkg::*;

  `LMX_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped under stall")
  `LMX_ASSERT_IMP(a_empty_head, out_valid && out_queue_empty, out_head_node == '0, "head set on empty queue")
  `LMX_ASSERT_IMP(a_grant_queue, out_valid && out_granted, !out_queue_empty, "grant with empty queue")
  `LMX_ASSERT_IMP(a_dest_rep, out_valid && (out_send_kind != KIND_REP), out_send_dest == '0, "destination set on non-REP")
  `LMX_ASSERT_IMP(a_none_clock, out_valid && (out_send_kind == KIND_NONE), out_send_clock == '0, "clock sent with no message")

endmodule

bind lamport_mutex_node lmx_checker u_lmx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_send_kind   (out_send_kind),
  .out_send_clock  (out_send_clock),
  .out_send_dest   (out_send_dest),
  .out_granted     (out_granted),
  .out_head_node   (out_head_node),
  .out_queue_empty (out_queue_empty)
);
